@@ src/u8dfa_pkg.sv @@
// ----------------------------------------------------------------------------
// u8dfa_pkg
// Shared types, constants and tables for the UTF-8 DFA decoder with a
// UTF-16 unit counter.
// ----------------------------------------------------------------------------
`default_nettype none

package u8dfa_pkg;

    // Width of the internal UTF-16 unit counter (8..32)
    localparam int COUNT_WIDTH = 16;
    localparam int SHOW_WIDTH  = 16;
    localparam int CP_WIDTH    = 21;

    // Queue depths and pointer widths
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);
    localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [3:0]             byte_class_t;

    // Byte classes
    localparam byte_class_t CLS_ASCII    = 4'd0;   // 00..7F
    localparam byte_class_t CLS_CONT_LO  = 4'd1;   // 80..8F
    localparam byte_class_t CLS_LEAD2    = 4'd2;   // C2..DF
    localparam byte_class_t CLS_LEAD3    = 4'd3;   // E1..EC, EE..EF
    localparam byte_class_t CLS_ED       = 4'd4;   // ED
    localparam byte_class_t CLS_F4       = 4'd5;   // F4
    localparam byte_class_t CLS_LEAD4    = 4'd6;   // F1..F3
    localparam byte_class_t CLS_CONT_HI  = 4'd7;   // A0..BF
    localparam byte_class_t CLS_BAD      = 4'd8;   // C0, C1, F5..FF
    localparam byte_class_t CLS_CONT_MID = 4'd9;   // 90..9F
    localparam byte_class_t CLS_E0       = 4'd10;  // E0
    localparam byte_class_t CLS_F0       = 4'd11;  // F0

    // DFA states: accept, sticky reject, and seven states inside a sequence
    typedef enum logic [3:0] {
        ST_ACCEPT = 4'd0,
        ST_REJECT = 4'd1,
        ST_S2     = 4'd2,
        ST_S3     = 4'd3,
        ST_S4     = 4'd4,
        ST_S5     = 4'd5,
        ST_S6     = 4'd6,
        ST_S7     = 4'd7,
        ST_S8     = 4'd8
    } dfa_state_t;

    // Classified byte handed from the front end to the back end
    typedef struct packed {
        logic [7:0]  data;
        byte_class_t cls;
        logic        term;
    } front_item_t;

    // One result beat
    typedef struct packed {
        logic [CP_WIDTH-1:0]   code_point;
        logic                  char_done;
        logic                  rejected;
        logic [SHOW_WIDTH-1:0] unit_count;
        logic                  at_end;
        logic                  string_valid;
    } result_t;

    // Map a byte to its character class
    function automatic byte_class_t byte_class(input logic [7:0] b);
        byte_class_t c;
        priority if (b < 8'h80) c = CLS_ASCII;
        else if (b < 8'h90)     c = CLS_CONT_LO;
        else if (b < 8'hA0)     c = CLS_CONT_MID;
        else if (b < 8'hC0)     c = CLS_CONT_HI;
        else if (b < 8'hC2)     c = CLS_BAD;
        else if (b < 8'hE0)     c = CLS_LEAD2;
        else if (b == 8'hE0)    c = CLS_E0;
        else if (b == 8'hED)    c = CLS_ED;
        else if (b < 8'hF0)     c = CLS_LEAD3;
        else if (b == 8'hF0)    c = CLS_F0;
        else if (b < 8'hF4)     c = CLS_LEAD4;
        else if (b == 8'hF4)    c = CLS_F4;
        else                    c = CLS_BAD;
        return c;
    endfunction

    // DFA transition table
    function automatic dfa_state_t dfa_next(input dfa_state_t st, input byte_class_t c);
        dfa_state_t n;
        n = ST_REJECT;
        unique case (st)
            ST_ACCEPT:
            begin
                unique case (c)
                    CLS_ASCII: n = ST_ACCEPT;
                    CLS_LEAD2: n = ST_S2;
                    CLS_LEAD3: n = ST_S3;
                    CLS_ED:    n = ST_S5;
                    CLS_F4:    n = ST_S8;
                    CLS_LEAD4: n = ST_S7;
                    CLS_E0:    n = ST_S4;
                    CLS_F0:    n = ST_S6;
                    default:   n = ST_REJECT;
                endcase
            end
            ST_S2:
            begin
                if (c == CLS_CONT_LO || c == CLS_CONT_HI || c == CLS_CONT_MID)
                    n = ST_ACCEPT;
            end
            ST_S3:
            begin
                if (c == CLS_CONT_LO || c == CLS_CONT_HI || c == CLS_CONT_MID)
                    n = ST_S2;
            end
            ST_S4:
            begin
                if (c == CLS_CONT_HI)
                    n = ST_S2;
            end
            ST_S5:
            begin
                if (c == CLS_CONT_LO || c == CLS_CONT_MID)
                    n = ST_S2;
            end
            ST_S6:
            begin
                if (c == CLS_CONT_HI || c == CLS_CONT_MID)
                    n = ST_S3;
            end
            ST_S7:
            begin
                if (c == CLS_CONT_LO || c == CLS_CONT_HI || c == CLS_CONT_MID)
                    n = ST_S3;
            end
            ST_S8:
            begin
                if (c == CLS_CONT_LO)
                    n = ST_S3;
            end
            default: n = ST_REJECT;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

@@ src/utf8_dfa_decoder_utf16_counter.sv @@
// ----------------------------------------------------------------------------
// utf8_dfa_decoder_utf16_counter
// Path: a byte is written into the input queue, then stepped by the back end into the output queue.
// Throughput: one byte per cycle while the output queue has room; the DFA step in the back end
// is combinational; two-entry queues sit before and after it.
// Reset: queues empty, DFA in accept state, accumulator zero, unit count one.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_dfa_decoder_utf16_counter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [20:0]      code_point,
    output logic             char_done,
    output logic             rejected,
    output logic [15:0]      unit_count,
    output logic             at_end,
    output logic             string_valid
);
    import u8dfa_pkg::*;

    logic        q_full;
    logic        q_push;
    front_item_t q_wr_item;
    logic        q_valid;
    front_item_t q_rd_item;
    logic        q_take;
    result_t     res;

    u8dfa_front u_front (
        .push      (push),
        .full      (full),
        .data_byte (data_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_wr_item)
    );

    u8dfa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_item  (q_wr_item),
        .q_full   (q_full),
        .rd_en    (q_take),
        .rd_valid (q_valid),
        .rd_item  (q_rd_item)
    );

    u8dfa_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_item  (q_rd_item),
        .in_take  (q_take),
        .pop      (pop),
        .empty    (empty),
        .res      (res)
    );

    assign code_point   = res.code_point;
    assign char_done    = res.char_done;
    assign rejected     = res.rejected;
    assign unit_count   = res.unit_count;
    assign at_end       = res.at_end;
    assign string_valid = res.string_valid;

    // Terminator beats carry no code point and no completed character
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && at_end) |-> (code_point == '0 && !char_done))
        else $error("terminator beat carries character data");

    // Validity is only reported on the terminator
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && string_valid) |-> (at_end && !rejected))
        else $error("string_valid outside terminator or with reject");

    // A completed character never coincides with the reject state or the terminator
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && char_done) |-> (!rejected && !at_end))
        else $error("char_done together with reject or terminator");

    // The back end only takes a classified byte that is present
    assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> q_valid)
        else $error("back end took from an empty queue");

endmodule

`default_nettype wire

@@ src/u8dfa_front.sv @@
// ----------------------------------------------------------------------------
// u8dfa_front
// Accepts input bytes, flags the terminator and looks up the byte class.
// ----------------------------------------------------------------------------
`default_nettype none

module u8dfa_front (
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  q_full,
    output logic                       q_push,
    output u8dfa_pkg::front_item_t     q_item
);
    import u8dfa_pkg::*;

    // Accept whenever the decoupling queue has room
    assign full   = q_full;
    assign q_push = push && !q_full;

    // Classify the byte
    always_comb
    begin
        q_item.data = data_byte;
        q_item.cls  = byte_class(data_byte);
        q_item.term = (data_byte == 8'h00);
    end

endmodule

`default_nettype wire

@@ src/u8dfa_queue.sv @@
// ----------------------------------------------------------------------------
// u8dfa_queue
// Short queue of classified bytes between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module u8dfa_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire u8dfa_pkg::front_item_t wr_item,
    output logic                        q_full,
    input  wire logic                   rd_en,
    output logic                        rd_valid,
    output u8dfa_pkg::front_item_t      rd_item
);
    import u8dfa_pkg::*;

    front_item_t                 mem [QUEUE_DEPTH];
    logic [PTR_WIDTH-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PTR_WIDTH-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [CNT_WIDTH-1:0]        cnt_reg, cnt_next;

    assign q_full   = (cnt_reg == CNT_WIDTH'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_item  = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + CNT_WIDTH'(1);
        else if (rd_en && !wr_en)
            cnt_next = cnt_reg - CNT_WIDTH'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_item;
    end

endmodule

`default_nettype wire

@@ src/u8dfa_back.sv @@
// ----------------------------------------------------------------------------
// u8dfa_back
// Runs the DFA, builds the code point, counts UTF-16 units and holds
// result beats in a two-entry output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module u8dfa_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire u8dfa_pkg::front_item_t in_item,
    output logic                        in_take,
    input  wire logic                   pop,
    output logic                        empty,
    output u8dfa_pkg::result_t          res
);
    import u8dfa_pkg::*;

    localparam int EXT_WIDTH = COUNT_WIDTH + SHOW_WIDTH;

    dfa_state_t               state_reg, state_next;
    logic [CP_WIDTH-1:0]      accum_reg, accum_next;
    count_t                   units_reg, units_next;

    result_t                  out_mem [QUEUE_DEPTH];
    logic [PTR_WIDTH-1:0]     owr_ptr_reg, owr_ptr_next;
    logic [PTR_WIDTH-1:0]     ord_ptr_reg, ord_ptr_next;
    logic [CNT_WIDTH-1:0]     ocnt_reg, ocnt_next;
    logic                     out_pop;

    result_t                  res_new;
    logic [7:0]               lead_bits;
    logic [COUNT_WIDTH:0]     units_sum;
    logic                     done;
    logic [EXT_WIDTH-1:0]     shown_ext;

    // Take a byte whenever the output queue has room
    assign in_take = in_valid && (ocnt_reg != CNT_WIDTH'(QUEUE_DEPTH));
    assign out_pop = pop && !empty;
    assign empty   = (ocnt_reg == '0);
    assign res     = out_mem[ord_ptr_reg];

    // Step the DFA, accumulator and counter for one byte
    always_comb
    begin
        state_next = state_reg;
        accum_next = accum_reg;
        units_next = units_reg;
        lead_bits  = (8'hFF >> in_item.cls) & in_item.data;
        units_sum  = '0;
        done       = 1'b0;
        shown_ext  = '0;
        res_new    = '0;

        if (in_item.term)
        begin
            // Report and restart the string
            shown_ext            = EXT_WIDTH'(units_reg);
            res_new.rejected     = (state_reg == ST_REJECT);
            res_new.string_valid = (state_reg == ST_ACCEPT);
            res_new.at_end       = 1'b1;
            state_next           = ST_ACCEPT;
            accum_next           = '0;
            units_next           = COUNT_WIDTH'(1);
        end
        else
        begin
            if (state_reg != ST_ACCEPT)
                accum_next = {accum_reg[CP_WIDTH-7:0], in_item.data[5:0]};
            else
                accum_next = CP_WIDTH'(lead_bits);
            state_next = dfa_next(state_reg, in_item.cls);
            done       = (state_next == ST_ACCEPT);
            if (done)
            begin
                // Saturating add of one or two units
                units_sum = {1'b0, units_reg}
                          + ((accum_next > CP_WIDTH'(20'hFFFF)) ? (COUNT_WIDTH+1)'(2)
                                                                  : (COUNT_WIDTH+1)'(1));
                units_next = units_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}}
                                                    : units_sum[COUNT_WIDTH-1:0];
            end
            shown_ext          = EXT_WIDTH'(units_next);
            res_new.code_point = accum_next;
            res_new.char_done  = done;
            res_new.rejected   = (state_next == ST_REJECT);
        end

        res_new.unit_count = (shown_ext > EXT_WIDTH'({SHOW_WIDTH{1'b1}}))
                           ? {SHOW_WIDTH{1'b1}} : shown_ext[SHOW_WIDTH-1:0];
    end

    // Hold decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCEPT;
            accum_reg <= '0;
            units_reg <= COUNT_WIDTH'(1);
        end
        else if (in_take)
        begin
            state_reg <= state_next;
            accum_reg <= accum_next;
            units_reg <= units_next;
        end
    end

    // Advance output queue pointers
    always_comb
    begin
        owr_ptr_next = owr_ptr_reg;
        ord_ptr_next = ord_ptr_reg;
        ocnt_next    = ocnt_reg;
        if (in_take)
            owr_ptr_next = (owr_ptr_reg == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : owr_ptr_reg + 1'b1;
        if (out_pop)
            ord_ptr_next = (ord_ptr_reg == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : ord_ptr_reg + 1'b1;
        if (in_take && !out_pop)
            ocnt_next = ocnt_reg + CNT_WIDTH'(1);
        else if (out_pop && !in_take)
            ocnt_next = ocnt_reg - CNT_WIDTH'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_ptr_reg <= '0;
            ord_ptr_reg <= '0;
            ocnt_reg    <= '0;
        end
        else
        begin
            owr_ptr_reg <= owr_ptr_next;
            ord_ptr_reg <= ord_ptr_next;
            ocnt_reg    <= ocnt_next;
        end
    end

    // Store result beats
    always_ff @(posedge clk)
    begin
        if (in_take)
            out_mem[owr_ptr_reg] <= res_new;
    end

endmodule

`default_nettype wire
